[rtl/core/assert_macros.svh]
// Assertion macros shared by the core RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define SID_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Condition must never be seen at a clock edge outside reset.
`define SID_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define SID_ASSERT(lbl, clk, rst, prop, msg)
`define SID_ASSERT_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

[rtl/core/sid_pkg.sv]
// Shared constants and types for the sorted insert deque.
package sid_pkg;

  localparam int DEPTH       = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int ADDR_W      = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(DEPTH + 1);

  localparam int OPCODE_W    = 3;
  localparam int VALUE_IN_W  = 32;
  localparam int VALUE_OUT_W = 32;
  localparam int STATUS_W    = 2;
  localparam int OCC_W       = 5;

  typedef logic [VALUE_WIDTH-1:0] value_t;

  typedef enum logic [OPCODE_W-1:0] {
    OP_INS_FRONT  = 3'd0,
    OP_INS_END    = 3'd1,
    OP_INS_SORTED = 3'd2,
    OP_REM_FRONT  = 3'd3,
    OP_REM_END    = 3'd4,
    OP_VIEW_FRONT = 3'd5,
    OP_VIEW_END   = 3'd6
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic [OPCODE_W-1:0]   opcode;
    logic [VALUE_IN_W-1:0] value_in;
  } in_item_t;

  typedef struct packed {
    logic [VALUE_OUT_W-1:0] value_out;
    logic [STATUS_W-1:0]    status;
    logic [OCC_W-1:0]       occupancy;
  } out_item_t;

endpackage

[rtl/core/sid_ram.sv]
// Generic simple dual-port RAM with one write port and one registered read port.
module sid_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/sorted_insert_deque_top.sv]
// Top level of the sorted insert deque: sequencer, entry RAM and result register.
//
// A bounded ordered list of up to DEPTH values. Each transfer on the input
// channel (in_valid/in_ready, in_data) carries one operation: insert at front,
// insert at end, sorted insert, remove front, remove end, view front or view
// end. Each operation gives exactly one transfer on the output channel
// (out_valid/out_ready, out_data) with the removed or viewed value, a status
// and the occupancy after the operation. The signed_compare register is
// written through cfg_we/cfg_wdata and selects signed or unsigned ordering.
// Entries live in a RAM with one write and one registered read port, and
// all shifting and searching walk through it one entry per cycle, with a
// single comparator used for the sorted search. An insert at end or into an
// empty list, a refused insert, an empty case and an unused opcode need no
// walk; a view or a remove at the end reads one entry; a remove at the front,
// an insert at the front and a sorted insert walk through the held entries.
// The block takes one item at a time; in_ready is high only while it is idle.
// A finished result waits in the output register, so a stalled receiver holds
// only the result and not the next input transfer. Reset empties the list,
// clears signed_compare and drops out_valid; no RAM clearing pass is needed.
`include "assert_macros.svh"

module sorted_insert_deque_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  sid_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output sid_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic               cfg_wdata
);

  import sid_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_SCAN,
    S_SHUP,
    S_SHDN,
    S_PUT,
    S_READ,
    S_DONE
  } state_t;

  state_t              state;
  logic [OPCODE_W-1:0] op;
  value_t              val;
  logic [CNT_W-1:0]    cnt;
  logic [ADDR_W-1:0]   idx;
  logic [ADDR_W-1:0]   pos;
  value_t              res_val;
  status_t             res_status;
  logic                signed_compare;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  value_t            ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  value_t            rd_data;

  logic [ADDR_W-1:0] last;
  value_t            sign_flip;
  logic              gt;

  assign in_ready  = (state == S_IDLE);
  assign last      = ADDR_W'(cnt - 1'b1);

  // Flipping the sign bit turns an unsigned compare into a two's complement one.
  assign sign_flip = value_t'(signed_compare) << (VALUE_WIDTH - 1);
  assign gt        = (rd_data ^ sign_flip) > (val ^ sign_flip);

  sid_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx;
    ram_wdata = rd_data;
    ram_raddr = idx;
    case (state)
      S_START: begin
        case (op)
          OP_INS_END: begin
            if (cnt != CNT_W'(DEPTH)) begin
              ram_we    = 1'b1;
              ram_waddr = ADDR_W'(cnt);
              ram_wdata = val;
            end
          end
          OP_INS_FRONT, OP_INS_SORTED: begin
            if (cnt == '0) begin
              ram_we    = 1'b1;
              ram_waddr = '0;
              ram_wdata = val;
            end
            ram_raddr = (op == OP_INS_FRONT) ? last : '0;
          end
          OP_REM_FRONT, OP_VIEW_FRONT: begin
            ram_raddr = '0;
          end
          OP_REM_END, OP_VIEW_END: begin
            ram_raddr = last;
          end
          default: begin
          end
        endcase
      end
      S_SCAN: begin
        ram_raddr = gt ? last : idx + 1'b1;
        // No stored entry is greater, so the value goes at the end.
        if (!gt && idx == last) begin
          ram_we    = 1'b1;
          ram_waddr = ADDR_W'(cnt);
          ram_wdata = val;
        end
      end
      S_SHUP: begin
        ram_we    = 1'b1;
        ram_waddr = idx + 1'b1;
        ram_wdata = rd_data;
        ram_raddr = idx - 1'b1;
      end
      S_SHDN: begin
        if (idx != '0) begin
          ram_we    = 1'b1;
          ram_waddr = idx - 1'b1;
          ram_wdata = rd_data;
        end
        ram_raddr = idx + 1'b1;
      end
      S_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = pos;
        ram_wdata = val;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      cnt            <= '0;
      signed_compare <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        signed_compare <= cfg_wdata;
      end
      // In the done state the output register is handled below.
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op    <= in_data.opcode;
            val   <= value_t'(in_data.value_in);
            state <= S_START;
          end
        end
        S_START: begin
          res_val    <= '0;
          res_status <= ST_DONE;
          case (op)
            OP_INS_FRONT, OP_INS_END, OP_INS_SORTED: begin
              if (cnt == CNT_W'(DEPTH)) begin
                res_status <= ST_FULL;
                state      <= S_DONE;
              end else if (op == OP_INS_END || cnt == '0) begin
                cnt   <= cnt + 1'b1;
                state <= S_DONE;
              end else if (op == OP_INS_FRONT) begin
                pos   <= '0;
                idx   <= last;
                state <= S_SHUP;
              end else begin
                idx   <= '0;
                state <= S_SCAN;
              end
            end
            OP_REM_FRONT, OP_REM_END, OP_VIEW_FRONT, OP_VIEW_END: begin
              if (cnt == '0) begin
                res_status <= ST_EMPTY;
                state      <= S_DONE;
              end else if (op == OP_REM_FRONT) begin
                idx   <= '0;
                state <= S_SHDN;
              end else begin
                state <= S_READ;
              end
            end
            default: begin
              state <= S_DONE;
            end
          endcase
        end
        S_SCAN: begin
          if (gt) begin
            pos   <= idx;
            idx   <= last;
            state <= S_SHUP;
          end else if (idx == last) begin
            cnt   <= cnt + 1'b1;
            state <= S_DONE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_SHUP: begin
          if (idx == pos) begin
            state <= S_PUT;
          end else begin
            idx <= idx - 1'b1;
          end
        end
        S_PUT: begin
          cnt   <= cnt + 1'b1;
          state <= S_DONE;
        end
        S_SHDN: begin
          // The first word read back is the front entry being removed.
          if (idx == '0) begin
            res_val <= rd_data;
          end
          if (idx == last) begin
            cnt   <= cnt - 1'b1;
            state <= S_DONE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_READ: begin
          res_val <= rd_data;
          if (op == OP_REM_END) begin
            cnt <= cnt - 1'b1;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid          <= 1'b1;
            out_data.value_out <= VALUE_OUT_W'(res_val);
            out_data.status    <= res_status;
            out_data.occupancy <= OCC_W'(cnt);
            state              <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `SID_ASSERT_NEVER(a_cnt_bound, clk, rst, cnt > CNT_W'(DEPTH), "entry count above depth")
  `SID_ASSERT(a_write_in_range, clk, rst, ram_we |-> (CNT_W'(ram_waddr) <= cnt), "RAM write past end of list")
  `SID_ASSERT(a_cnt_step, clk, rst, !$stable(cnt) |-> ((cnt == $past(cnt) + 1'b1) || (cnt == $past(cnt) - 1'b1)), "entry count moved by more than one")
  `SID_ASSERT(a_out_from_done, clk, rst, $rose(out_valid) |-> $past(state == S_DONE), "result presented outside the done state")
  `SID_ASSERT(a_full_occupancy, clk, rst, (out_valid && out_data.status == ST_FULL) |-> (out_data.occupancy == OCC_W'(DEPTH)), "full status with list not full")

endmodule
